// File: rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants for the oriented box overlap tester.
// ----------------------------------------------------------------------------
package obb_pkg;

  // Digit width of the shared multiplier; one digit is retired per cycle.
  localparam int DIGIT_W = 8;

  // Row codes inside a box; the box itself is the top opcode bit.
  localparam logic [1:0] ROW_LAST   = 2'd2;
  localparam logic [1:0] ROW_CENTER = 2'd3;
  localparam logic       BOX_A      = 1'b0;
  localparam logic       BOX_B      = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_AXIS  = 7'b0000010,
    ST_CROSS = 7'b0000100,
    ST_DIST  = 7'b0001000,
    ST_PROJ  = 7'b0010000,
    ST_EXT   = 7'b0100000,
    ST_CMP   = 7'b1000000
  } state_t;

  // Sub-steps of one multiply: wait for read data, launch, run.
  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_GO   = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  // Cyclic successor and predecessor of a vector component index.
  function automatic logic [1:0] next_comp(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prev_comp(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/obb_ram.sv
// ----------------------------------------------------------------------------
// obb_ram
// Generic synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module obb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// File: rtl/obb_mac.sv
// ----------------------------------------------------------------------------
// obb_mac
// Digit-serial signed multiplier: wide operand times narrow operand, one
// digit of the narrow operand per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
module obb_mac #(
  parameter int A_W = 100,
  parameter int B_W = 33
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [A_W-1:0]        a,
  input  logic signed [B_W-1:0]        b,
  output logic                         done,
  output logic signed [A_W+B_W-1:0]    prod
);

  localparam int P_W  = A_W + B_W;
  localparam int DIG  = obb_pkg::DIGIT_W;
  localparam int NDIG = (B_W + DIG - 1) / DIG;
  localparam int BW   = NDIG * DIG;
  localparam int CW   = $clog2(NDIG + 1);

  logic [A_W-1:0]        am_r;
  logic [BW-1:0]         bm_r;
  logic                  neg_r;
  logic [P_W-1:0]        sum_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic signed [P_W-1:0] prod_r;

  logic [A_W-1:0]     a_mag;
  logic [B_W-1:0]     b_mag;
  logic [A_W+DIG-1:0] part;
  logic [P_W-1:0]     sum_nxt;
  logic               last;

  assign a_mag   = a[A_W-1] ? A_W'(-a) : A_W'(a);
  assign b_mag   = b[B_W-1] ? B_W'(-b) : B_W'(b);
  assign part    = am_r * bm_r[BW-1 -: DIG];
  assign sum_nxt = (sum_r << DIG) + P_W'(part);
  assign last    = (cnt_r == CW'(NDIG - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= a_mag;
      bm_r  <= BW'(b_mag);
      neg_r <= a[A_W-1] ^ b[B_W-1];
      sum_r <= '0;
    end else if (run_r) begin
      sum_r <= sum_nxt;
      bm_r  <= bm_r << DIG;
      if (last) begin
        prod_r <= neg_r ? -$signed(sum_nxt) : $signed(sum_nxt);
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: rtl/obb_overlap_test.sv
// ----------------------------------------------------------------------------
// obb_overlap_test
// Exact separating axis overlap test of two oriented boxes in 3D.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | flow
//  ---------+-----------------------------------------+------------------------
//  input    | start, busy, in_opcode, in_vec_x/y/z,   | taken when start & !busy
//           | in_half_extent, in_compute_now          |
//  result   | out_valid, out_overlap                  | one-cycle strobe
//
//  A load transaction leaves the block idle and the next may follow at once.
//  A compute transaction runs up to 15 axes, each about 30 multiplies on the
//  single digit-serial multiplier; the first separating axis ends the test
//  early. busy is high for the whole test.
//  Operands are read from the vector and extent RAMs on each multiply.
//  Reset clears control only; RAM contents are undefined until loaded.
//  The result strobe is not stallable and lasts one cycle.
// ----------------------------------------------------------------------------
module obb_overlap_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic [30:0]        in_half_extent,
  input  logic               in_compute_now,
  output logic               out_valid,
  output logic               out_overlap
);

  localparam int W     = COORD_WIDTH;
  localparam int NW    = W + 1;
  localparam int SW    = 2 * W + 1;
  localparam int PJW   = 3 * W + 3;
  localparam int WW    = 3 * W + 4;
  localparam int PW    = WW + NW;
  localparam int ACC_W = 4 * W + 8;
  localparam int CMPW  = ACC_W + FRAC_BITS;
  localparam int EW    = W - 1;
  localparam int VW    = 3 * W;
  localparam int RW    = (W > 32) ? W : 32;
  localparam int RE    = (EW > 31) ? EW : 31;

  obb_pkg::state_t state_r, state_nxt;
  obb_pkg::phase_t ph_r, ph_nxt;

  logic       fb_r, fb_nxt;
  logic [1:0] ci_r, ci_nxt;
  logic [1:0] cj_r, cj_nxt;
  logic       cross_r, cross_nxt;
  logic       kb_r, kb_nxt;
  logic [1:0] kr_r, kr_nxt;
  logic [1:0] c_r, c_nxt;
  logic       t_r, t_nxt;

  logic signed [SW-1:0]    s_r [3];
  logic signed [SW-1:0]    s_nxt [3];
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0]        dterm_r, dterm_nxt;
  logic [ACC_W-1:0]        rsum_r, rsum_nxt;
  logic [PJW-1:0]          proj_r, proj_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_overlap_r, out_overlap_nxt;

  // Load path
  logic          accept;
  logic [RW-1:0] raw_x, raw_y, raw_z;
  logic [RE-1:0] raw_e;
  logic [VW-1:0] wvec;
  logic          ext_we;

  assign accept = start && (state_r == obb_pkg::ST_IDLE);
  assign raw_x  = RW'($unsigned(in_vec_x));
  assign raw_y  = RW'($unsigned(in_vec_y));
  assign raw_z  = RW'($unsigned(in_vec_z));
  assign raw_e  = RE'(in_half_extent);
  assign wvec   = {raw_z[W-1:0], raw_y[W-1:0], raw_x[W-1:0]};
  assign ext_we = accept && (in_opcode[1:0] != obb_pkg::ROW_CENTER);

  logic [2:0]    raddr0, raddr1, eaddr;
  logic [VW-1:0] vq0, vq1;
  logic [EW-1:0] eq;

  obb_ram #(.WIDTH(VW), .DEPTH(8)) u_vec_ram (
    .clk    (clk),
    .we     (accept),
    .waddr  (in_opcode),
    .wdata  (wvec),
    .raddr0 (raddr0),
    .rdata0 (vq0),
    .raddr1 (raddr1),
    .rdata1 (vq1)
  );

  obb_ram #(.WIDTH(EW), .DEPTH(8)) u_ext_ram (
    .clk    (clk),
    .we     (ext_we),
    .waddr  (in_opcode),
    .wdata  (raw_e[EW-1:0]),
    .raddr0 (eaddr),
    .rdata0 (eq),
    .raddr1 (eaddr),
    .rdata1 ()
  );

  // Read addresses follow the sequencer counters
  always_comb begin
    case (state_r)
      obb_pkg::ST_AXIS:  raddr0 = {fb_r, ci_r};
      obb_pkg::ST_CROSS: raddr0 = {obb_pkg::BOX_A, ci_r};
      obb_pkg::ST_DIST:  raddr0 = {obb_pkg::BOX_A, obb_pkg::ROW_CENTER};
      default:           raddr0 = {kb_r, kr_r};
    endcase
    if (state_r == obb_pkg::ST_CROSS) begin
      raddr1 = {obb_pkg::BOX_B, cj_r};
    end else begin
      raddr1 = {obb_pkg::BOX_B, obb_pkg::ROW_CENTER};
    end
    eaddr = {kb_r, kr_r};
  end

  // Component split of the read data
  logic signed [W-1:0] v0c [3];
  logic signed [W-1:0] v1c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v0c[i] = vq0[i*W +: W];
      v1c[i] = vq1[i*W +: W];
    end
  end

  // Multiplier operand select
  logic                 mac_start;
  logic signed [WW-1:0] mac_a;
  logic signed [NW-1:0] mac_b;
  logic                 mac_done;
  logic signed [PW-1:0] mac_prod;
  logic [1:0]           ca, cb;

  always_comb begin
    ca = t_r ? obb_pkg::prev_comp(c_r) : obb_pkg::next_comp(c_r);
    cb = t_r ? obb_pkg::next_comp(c_r) : obb_pkg::prev_comp(c_r);
    case (state_r)
      obb_pkg::ST_CROSS: begin
        mac_a = WW'(v0c[ca]);
        mac_b = NW'(v1c[cb]);
      end
      obb_pkg::ST_DIST: begin
        mac_a = WW'(s_r[c_r]);
        mac_b = NW'(v1c[c_r]) - NW'(v0c[c_r]);
      end
      obb_pkg::ST_EXT: begin
        mac_a = WW'($signed({1'b0, proj_r}));
        mac_b = $signed({2'b00, eq});
      end
      default: begin
        mac_a = WW'(s_r[c_r]);
        mac_b = NW'(v0c[c_r]);
      end
    endcase
  end

  obb_mac #(.A_W(WW), .B_W(NW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .done  (mac_done),
    .prod  (mac_prod)
  );

  logic signed [ACC_W-1:0] acc_add, acc_sub;
  logic [ACC_W-1:0]        acc_abs;
  logic                    separated;

  assign acc_add   = acc_r + ACC_W'(mac_prod);
  assign acc_sub   = acc_r - ACC_W'(mac_prod);
  assign acc_abs   = acc_add[ACC_W-1] ? ACC_W'(-acc_add) : ACC_W'(acc_add);
  assign separated = (CMPW'(dterm_r) << FRAC_BITS) > CMPW'(rsum_r);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    ph_nxt          = ph_r;
    fb_nxt          = fb_r;
    ci_nxt          = ci_r;
    cj_nxt          = cj_r;
    cross_nxt       = cross_r;
    kb_nxt          = kb_r;
    kr_nxt          = kr_r;
    c_nxt           = c_r;
    t_nxt           = t_r;
    s_nxt           = s_r;
    acc_nxt         = acc_r;
    dterm_nxt       = dterm_r;
    rsum_nxt        = rsum_r;
    proj_nxt        = proj_r;
    out_valid_nxt   = 1'b0;
    out_overlap_nxt = out_overlap_r;
    mac_start       = 1'b0;

    case (state_r)
      obb_pkg::ST_IDLE: begin
        if (accept && in_compute_now) begin
          state_nxt = obb_pkg::ST_AXIS;
          ph_nxt    = obb_pkg::PH_WAIT;
          fb_nxt    = obb_pkg::BOX_A;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
          cross_nxt = 1'b0;
        end
      end

      obb_pkg::ST_AXIS: begin
        if (ph_r == obb_pkg::PH_WAIT) begin
          ph_nxt = obb_pkg::PH_GO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            s_nxt[i] = SW'(v0c[i]);
          end
          acc_nxt   = '0;
          c_nxt     = 2'd0;
          state_nxt = obb_pkg::ST_DIST;
          ph_nxt    = obb_pkg::PH_WAIT;
        end
      end

      obb_pkg::ST_CROSS: begin
        case (ph_r)
          obb_pkg::PH_WAIT: ph_nxt = obb_pkg::PH_GO;
          obb_pkg::PH_GO: begin
            mac_start = 1'b1;
            ph_nxt    = obb_pkg::PH_RUN;
          end
          default: begin
            if (mac_done) begin
              if (!t_r) begin
                acc_nxt = acc_add;
                t_nxt   = 1'b1;
                ph_nxt  = obb_pkg::PH_GO;
              end else begin
                s_nxt[c_r] = SW'(acc_sub);
                acc_nxt    = '0;
                t_nxt      = 1'b0;
                if (c_r == obb_pkg::ROW_LAST) begin
                  c_nxt     = 2'd0;
                  state_nxt = obb_pkg::ST_DIST;
                  ph_nxt    = obb_pkg::PH_WAIT;
                end else begin
                  c_nxt  = c_r + 2'd1;
                  ph_nxt = obb_pkg::PH_GO;
                end
              end
            end
          end
        endcase
      end

      obb_pkg::ST_DIST, obb_pkg::ST_PROJ: begin
        case (ph_r)
          obb_pkg::PH_WAIT: ph_nxt = obb_pkg::PH_GO;
          obb_pkg::PH_GO: begin
            mac_start = 1'b1;
            ph_nxt    = obb_pkg::PH_RUN;
          end
          default: begin
            if (mac_done) begin
              if (c_r == obb_pkg::ROW_LAST) begin
                acc_nxt = '0;
                c_nxt   = 2'd0;
                if (state_r == obb_pkg::ST_DIST) begin
                  dterm_nxt = acc_abs;
                  rsum_nxt  = '0;
                  kb_nxt    = obb_pkg::BOX_A;
                  kr_nxt    = 2'd0;
                  state_nxt = obb_pkg::ST_PROJ;
                  ph_nxt    = obb_pkg::PH_WAIT;
                end else begin
                  // extent read address has been stable since the projection began
                  proj_nxt  = PJW'(acc_abs);
                  state_nxt = obb_pkg::ST_EXT;
                  ph_nxt    = obb_pkg::PH_GO;
                end
              end else begin
                acc_nxt = acc_add;
                c_nxt   = c_r + 2'd1;
                ph_nxt  = obb_pkg::PH_GO;
              end
            end
          end
        endcase
      end

      obb_pkg::ST_EXT: begin
        if (ph_r == obb_pkg::PH_RUN) begin
          if (mac_done) begin
            rsum_nxt = rsum_r + ACC_W'($unsigned(mac_prod));
            ph_nxt   = obb_pkg::PH_WAIT;
            if (kb_r == obb_pkg::BOX_B && kr_r == obb_pkg::ROW_LAST) begin
              state_nxt = obb_pkg::ST_CMP;
            end else begin
              state_nxt = obb_pkg::ST_PROJ;
              if (kr_r == obb_pkg::ROW_LAST) begin
                kr_nxt = 2'd0;
                kb_nxt = obb_pkg::BOX_B;
              end else begin
                kr_nxt = kr_r + 2'd1;
              end
            end
          end
        end else begin
          mac_start = 1'b1;
          ph_nxt    = obb_pkg::PH_RUN;
        end
      end

      obb_pkg::ST_CMP: begin
        ph_nxt  = obb_pkg::PH_WAIT;
        acc_nxt = '0;
        c_nxt   = 2'd0;
        t_nxt   = 1'b0;
        if (separated) begin
          out_valid_nxt   = 1'b1;
          out_overlap_nxt = 1'b0;
          state_nxt       = obb_pkg::ST_IDLE;
        end else if (cross_r && ci_r == obb_pkg::ROW_LAST && cj_r == obb_pkg::ROW_LAST) begin
          out_valid_nxt   = 1'b1;
          out_overlap_nxt = 1'b1;
          state_nxt       = obb_pkg::ST_IDLE;
        end else if (cross_r) begin
          state_nxt = obb_pkg::ST_CROSS;
          if (cj_r == obb_pkg::ROW_LAST) begin
            cj_nxt = 2'd0;
            ci_nxt = ci_r + 2'd1;
          end else begin
            cj_nxt = cj_r + 2'd1;
          end
        end else if (fb_r == obb_pkg::BOX_B && ci_r == obb_pkg::ROW_LAST) begin
          // face axes done, move to the edge cross products
          cross_nxt = 1'b1;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
          state_nxt = obb_pkg::ST_CROSS;
        end else begin
          state_nxt = obb_pkg::ST_AXIS;
          if (ci_r == obb_pkg::ROW_LAST) begin
            ci_nxt = 2'd0;
            fb_nxt = obb_pkg::BOX_B;
          end else begin
            ci_nxt = ci_r + 2'd1;
          end
        end
      end

      default: begin
        state_nxt = obb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obb_pkg::ST_IDLE;
      ph_r        <= obb_pkg::PH_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r          <= fb_nxt;
    ci_r          <= ci_nxt;
    cj_r          <= cj_nxt;
    cross_r       <= cross_nxt;
    kb_r          <= kb_nxt;
    kr_r          <= kr_nxt;
    c_r           <= c_nxt;
    t_r           <= t_nxt;
    s_r           <= s_nxt;
    acc_r         <= acc_nxt;
    dterm_r       <= dterm_nxt;
    rsum_r        <= rsum_nxt;
    proj_r        <= proj_nxt;
    out_overlap_r <= out_overlap_nxt;
  end

  assign busy        = (state_r != obb_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule

// File: rtl/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker
// Port-level checks of the overlap tester's command and result timing.
// ----------------------------------------------------------------------------
module obb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_compute_now,
  input logic out_valid
);

  // a compute transaction holds the block busy
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_compute_now) |=> busy)
    else $error("compute transaction did not raise busy");

  // a load transaction finishes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_compute_now) |=> (!busy && !out_valid))
    else $error("load transaction caused busy or a result");

  // a result ends the test
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result strobe without end of test");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind obb_overlap_test obb_checker u_obb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_compute_now (in_compute_now),
  .out_valid      (out_valid)
);

// File: tb/sv/obb_overlap_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_overlap_test_tb
// Loads box rows over the command port, runs overlap tests and checks each result
// strobe against a directed value or an exact wide-integer separating axis predictor.
// ----------------------------------------------------------------------------
module obb_overlap_test_tb;

  localparam int FRAC      = 16;
  localparam int N_ITEMS   = 1450;
  localparam int IDLE_MAX  = 40000;
  localparam int DRAIN_CYC = 40;
  localparam int NO_CHECK  = -1;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] x, y, z;
    logic [30:0]        ext;
    logic               comp;
    int                 want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_opcode = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic [30:0]        in_half_extent = '0;
  logic               in_compute_now = 1'b0;
  logic               out_valid, out_overlap;

  obb_overlap_test dut (.*);

  always #5 clk = ~clk;

  // Predictor's own copy of the box store.
  logic signed [31:0] box_vec [8][3];
  logic [30:0]        box_ext [6];
  logic [7:0]         rows_loaded = '0;
  int                 overlap_q [$];
  bit                 failed = 1'b0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 n_sent = 0;

  function automatic wide_t mag(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic wide_t dot(input wide_t a [3], input wide_t b [3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic bit splits(input wide_t s [3], input wide_t gap [3]);
    wide_t d, reach, ax [3];
    d = mag(dot(gap, s)) <<< FRAC;
    reach = '0;
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) ax[c] = box_vec[(k / 3) * 4 + k % 3][c];
      reach += mag(dot(ax, s)) * $signed({225'b0, box_ext[k]});
    end
    return d > reach;
  endfunction

  function automatic bit boxes_overlap();
    wide_t gap [3], s [3], a [3], b [3];
    for (int c = 0; c < 3; c++) gap[c] = wide_t'(box_vec[7][c]) - wide_t'(box_vec[3][c]);
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) s[c] = box_vec[(k / 3) * 4 + k % 3][c];
      if (splits(s, gap)) return 1'b0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          a[c] = box_vec[i][c];
          b[c] = box_vec[4 + j][c];
        end
        s[0] = a[1] * b[2] - a[2] * b[1];
        s[1] = a[2] * b[0] - a[0] * b[2];
        s[2] = a[0] * b[1] - a[1] * b[0];
        if (splits(s, gap)) return 1'b0;
      end
    return 1'b1;
  endfunction

  function automatic void store_row(input row_t r);
    box_vec[r.op][0] = r.x;
    box_vec[r.op][1] = r.y;
    box_vec[r.op][2] = r.z;
    if (r.op[1:0] != obb_pkg::ROW_CENTER) box_ext[r.op[2] * 3 + r.op[1:0]] = r.ext;
    rows_loaded[r.op] = 1'b1;
    if (r.comp) overlap_q.push_back(r.want == NO_CHECK ? int'(boxes_overlap()) : r.want);
  endfunction

  // Offer one transaction; hold it until taken, then drop or keep start per burst.
  task automatic issue(input row_t r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    start          <= 1'b1;
    in_opcode      <= r.op;
    in_vec_x       <= r.x;
    in_vec_y       <= r.y;
    in_vec_z       <= r.z;
    in_half_extent <= r.ext;
    in_compute_now <= r.comp;
    do @(posedge clk); while (busy);
    store_row(r);
    n_sent++;
  endtask

  function automatic row_t mk(input logic [2:0] op, input logic signed [31:0] x, y, z,
                              input logic [30:0] ext, input logic comp, input int want);
    row_t r;
    r.op = op; r.x = x; r.y = y; r.z = z; r.ext = ext; r.comp = comp; r.want = want;
    return r;
  endfunction

  function automatic row_t rand_row(input logic [2:0] op, input bit comp);
    return mk(op, $urandom, $urandom, $urandom, 31'($urandom), comp, NO_CHECK);
  endfunction

  // Load one box as a signed permutation frame or random vectors, rows shuffled.
  task automatic load_box(input logic box, input bit last_computes);
    int perm [3], order [4], t, k, lim;
    logic signed [31:0] v [3];
    bit framed;
    framed = $urandom_range(0, 3) != 0;
    lim = 1 << $urandom_range(14, 20);
    perm = '{0, 1, 2};
    order = '{0, 1, 2, 3};
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[k]; perm[k] = t;
    end
    for (int i = 3; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i]; order[k] = order[k] ^ 0; order[i] = order[k]; order[k] = t;
    end
    for (int n = 0; n < 4; n++) begin
      logic [2:0] op;
      op = {box, 2'(order[n])};
      if (order[n] == 3) begin
        for (int c = 0; c < 3; c++)
          v[c] = framed ? $signed($urandom_range(0, 2 * lim)) - lim : $urandom;
      end else begin
        for (int c = 0; c < 3; c++)
          v[c] = (c == perm[order[n]]) ? ($urandom_range(0, 1) ? 32'sh10000 : -32'sh10000)
                                       : 32'sd0;
        if (!framed) for (int c = 0; c < 3; c++) v[c] = $urandom;
      end
      issue(mk(op, v[0], v[1], v[2], framed ? 31'($urandom_range(0, lim)) : 31'($urandom),
               last_computes && n == 3, NO_CHECK));
    end
  endtask

  always @(posedge clk) begin
    if (out_valid) begin
      if (overlap_q.size() == 0) begin
        $error("overlap: result strobe with no test pending, actual %0d", out_overlap);
        failed = 1'b1;
      end else if (out_overlap !== overlap_q[0][0]) begin
        $error("overlap: expected %0d actual %0d", overlap_q[0], out_overlap);
        failed = 1'b1;
        void'(overlap_q.pop_front());
      end else begin
        void'(overlap_q.pop_front());
      end
    end
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t directed [$];

  initial begin
    localparam logic signed [31:0] ONE = 32'sh10000;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic [30:0]        E_ONE = 31'h10000;
    localparam logic [30:0]        E_MAX = 31'h7fffffff;
    localparam logic [30:0]        E_0 = 31'h0;
    int pick;
    directed = '{
      mk(3'd0, ONE, 0, 0, E_ONE, 1'b0, NO_CHECK),
      mk(3'd1, 0, ONE, 0, E_ONE, 1'b0, NO_CHECK),
      mk(3'd2, 0, 0, ONE, E_ONE, 1'b0, NO_CHECK),
      mk(3'd3, 0, 0, 0, E_MAX, 1'b0, NO_CHECK),         // centre ignores the extent
      mk(3'd4, ONE, 0, 0, E_ONE, 1'b0, NO_CHECK),
      mk(3'd5, 0, ONE, 0, E_ONE, 1'b0, NO_CHECK),
      mk(3'd6, 0, 0, ONE, E_ONE, 1'b0, NO_CHECK),
      mk(3'd7, 0, 0, 0, E_0, 1'b1, 1),                  // coincident boxes, parallel axes
      mk(3'd7, 10 * ONE, 0, 0, E_0, 1'b1, 0),           // far apart along x
      mk(3'd7, 2 * ONE, 0, 0, E_0, 1'b1, 1),            // touching faces do not separate
      mk(3'd6, 0, 0, ONE, E_0, 1'b1, 1),                // zero extent, store and test
      mk(3'd7, MAXV, MAXV, MAXV, E_0, 1'b1, 0),
      mk(3'd3, MINV, MINV, MINV, E_0, 1'b1, 0),
      mk(3'd0, MAXV, MINV, MAXV, E_MAX, 1'b0, NO_CHECK),
      mk(3'd5, MINV, MAXV, -1, E_MAX, 1'b1, NO_CHECK),
      mk(3'd1, ONE, ONE, 0, E_MAX, 1'b0, NO_CHECK),
      mk(3'd4, ONE, -ONE, ONE, E_MAX, 1'b1, NO_CHECK),
      mk(3'd2, 0, 0, 0, E_0, 1'b1, NO_CHECK),           // zero axis: degenerate crosses
      mk(3'd3, 0, 0, 0, E_MAX, 1'b1, NO_CHECK)
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) issue(directed[i]);

    while (n_sent < N_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        load_box(obb_pkg::BOX_A, 1'b0);
        load_box(obb_pkg::BOX_B, 1'b1);
      end else if (pick < 9) begin
        repeat ($urandom_range(0, 2)) issue(rand_row(3'($urandom), 1'b0));
        issue(rand_row(3'($urandom), 1'b1));
      end else begin
        logic [2:0] op;
        op = 3'($urandom);
        issue(rand_row(op, $urandom_range(0, 1) && (rows_loaded | (8'd1 << op)) == 8'hff));
      end
    end
    start <= 1'b0;

    while (overlap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: obb_overlap_test.f
rtl/obb_pkg.sv
rtl/obb_ram.sv
rtl/obb_mac.sv
rtl/obb_overlap_test.sv
rtl/obb_checker.sv
tb/sv/obb_overlap_test_tb.sv
